### rtl/core/assert_macros.svh
// assertion macros shared by the tag parser rtl
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain invariant, checked on every edge out of reset
`define MTSP_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// implication, overlapping or next-cycle as written by the caller
`define MTSP_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/core/mtsp_pkg.sv
// types and constants for the base-modification tag parser
// no dependencies; used by the channel interfaces and every module
package mtsp_pkg;

  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int CODE_ID_W   = 24;
  localparam int DIGIT_CNT_W = 4;
  localparam int SKIP_W      = 32;

  localparam logic [DIGIT_CNT_W-1:0] DIGIT_CNT_MAX = 4'd15;
  localparam logic [SKIP_W-1:0] NUM_CAP     = 32'h8000_0000;
  localparam logic [SKIP_W-1:0] NUM_POS_MAX = 32'h7FFF_FFFF;

  // power of two, pointers wrap naturally
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    SEG_BASE,
    SEG_STRAND,
    SEG_CODE_START,
    SEG_CODE_NUM,
    SEG_CODE_LET,
    SEG_SKIP
  } seg_phase_t;

  typedef enum logic [2:0] {
    SK_EXPECT,
    SK_COMMA,
    SK_MINUS,
    SK_DIGITS,
    SK_STOP
  } skip_phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_SKIP   = 2'd1,
    KIND_END    = 2'd2
  } item_kind_t;

  typedef enum logic [1:0] {
    FLAG_NONE  = 2'd0,
    FLAG_QUEST = 2'd1,
    FLAG_DOT   = 2'd2
  } code_flag_t;

  // everything one character produces: up to header, skip and end
  typedef struct packed {
    logic                   hdr_v;
    logic                   skip_v;
    logic                   end_v;
    logic [7:0]             base;
    logic [7:0]             strand;
    logic                   numeric;
    logic [CODE_ID_W-1:0]   code;
    logic [DIGIT_CNT_W-1:0] count;
    code_flag_t             flag;
    logic [SKIP_W-1:0]      skip_val;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### rtl/core/mtsp_channels.sv
// valid/ready channel interfaces for the tag parser
// depends on mtsp_pkg for field widths
interface mtsp_char_if;
  import mtsp_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       final_char;

  modport source (output valid, output text_char, output final_char, input ready);
  modport sink   (input valid, input text_char, input final_char, output ready);
endinterface

interface mtsp_item_if;
  import mtsp_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [1:0]                    item_kind;
  logic [7:0]                    base_char;
  logic [7:0]                    strand_char;
  logic                          code_is_numeric;
  logic [CODE_ID_W-1:0]          code_id;
  logic [DIGIT_CNT_W-1:0]        code_digit_count;
  logic [1:0]                    code_flag;
  logic signed [SKIP_W-1:0]      skip_value;
  logic                          run_end;

  modport source (
    output valid, output item_kind, output base_char, output strand_char,
    output code_is_numeric, output code_id, output code_digit_count,
    output code_flag, output skip_value, output run_end, input ready
  );
  modport sink (
    input valid, input item_kind, input base_char, input strand_char,
    input code_is_numeric, input code_id, input code_digit_count,
    input code_flag, input skip_value, input run_end, output ready
  );
endinterface

### rtl/core/mm_tag_stream_parser_top.sv
// top level of the base-modification tag parser
// depends on mtsp_pkg, mtsp_channels, mtsp_front, mtsp_queue and mtsp_back
//
// The parser takes one tag character per transaction and can accept a new
// character every cycle while the queue is not full. Each character yields
// zero to three results (header, skip value, segment end), the last marked
// with run_end. The front end parses combinationally and writes the results
// of a character as one bundle into a four-entry queue; the back end sends
// one result per cycle from a registered output while the output is taken,
// and the sustained input rate is one character per cycle as long as results
// average no more than one per character and the output is not stalled. The
// first result of a character passes through the queue and the registered
// output stage before it is presented. Input ready falls only when the queue
// is full. Numeric mod codes saturate at 2^CODE_BITS-1 and are shown in 24
// bits.
module mm_tag_stream_parser_top #(
  parameter int CODE_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  mtsp_char_if.sink   in_ch,
  mtsp_item_if.source out_ch
);
  import mtsp_pkg::*;

  logic      push, pop;
  bundle_t   push_data, head;
  q_status_t q_st;

  mtsp_front #(
    .CODE_BITS (CODE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_st      (q_st),
    .push      (push),
    .push_data (push_data)
  );

  mtsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_st      (q_st)
  );

  mtsp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_st   (q_st),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

### rtl/core/mtsp_front.sv
// front end: takes one character per transaction, runs the segment parser
// and writes the resulting bundle into the queue; depends on mtsp_pkg
`include "assert_macros.svh"

module mtsp_front #(
  parameter int CODE_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mtsp_char_if.sink             in_ch,
  input  mtsp_pkg::q_status_t   q_st,
  output logic                  push,
  output mtsp_pkg::bundle_t     push_data
);
  import mtsp_pkg::*;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic num_ok(input logic [SKIP_W-1:0] mag, input logic neg,
                                  input logic ovf);
    return !ovf && (neg || (mag <= NUM_POS_MAX));
  endfunction

  seg_phase_t             seg_r, seg_fed, seg_nxt;
  skip_phase_t            skip_r, skip_fed, skip_nxt;
  logic [7:0]             base_r, base_fed, base_nxt;
  logic [7:0]             strand_r, strand_fed, strand_nxt;
  logic [CODE_BITS-1:0]   code_r, code_fed, code_nxt;
  logic [DIGIT_CNT_W-1:0] cnt_r, cnt_fed, cnt_nxt;
  logic                   num_r, num_fed, num_nxt;
  logic [SKIP_W-1:0]      mag_r, mag_fed, mag_nxt;
  logic                   neg_r, neg_fed, neg_nxt;
  logic                   ovf_r, ovf_fed, ovf_nxt;

  logic [7:0]             ch;
  logic                   accept, is_semi, fin, ch_dig, ch_flag;
  logic [3:0]             ch_val;
  logic                   run_skip, do_start;

  logic [CODE_BITS+3:0]   code_ext, code_prod;
  logic [CODE_BITS-1:0]   code_acc;
  logic [SKIP_W+2:0]      mag_ext, mag_prod;
  logic [SKIP_W-1:0]      mag_acc;
  logic                   mag_sat;

  logic                   feed_hdr, feed_skip, end_hdr, end_skip, end_any;

  assign ch      = in_ch.text_char;
  assign in_ch.ready = !q_st.full;
  assign accept  = in_ch.valid && in_ch.ready;
  assign is_semi = (ch == CH_SEMI);
  assign fin     = is_semi || in_ch.final_char;
  assign ch_dig  = is_digit(ch);
  assign ch_val  = 4'(ch - CH_ZERO);
  assign ch_flag = (ch == CH_QUEST) || (ch == CH_DOT);

  // times ten plus digit, saturating at the code width
  always_comb begin
    code_ext  = (CODE_BITS+4)'(code_r);
    code_prod = (code_ext << 3) + (code_ext << 1) + (CODE_BITS+4)'(ch_val);
    if (code_prod > (CODE_BITS+4)'({CODE_BITS{1'b1}})) begin
      code_acc = {CODE_BITS{1'b1}};
    end else begin
      code_acc = code_prod[CODE_BITS-1:0];
    end
  end

  // skip magnitude times ten plus digit, held at 2^31 on overflow
  always_comb begin
    mag_ext  = (SKIP_W+3)'(mag_r);
    mag_prod = (mag_ext << 3) + (mag_ext << 1) + (SKIP_W+3)'(ch_val);
    mag_sat  = mag_prod > (SKIP_W+3)'(NUM_CAP);
    mag_acc  = mag_sat ? NUM_CAP : mag_prod[SKIP_W-1:0];
  end

  // next state: feed the character, then clear on segment end
  always_comb begin
    seg_fed    = seg_r;
    skip_fed   = skip_r;
    base_fed   = base_r;
    strand_fed = strand_r;
    code_fed   = code_r;
    cnt_fed    = cnt_r;
    num_fed    = num_r;
    mag_fed    = mag_r;
    neg_fed    = neg_r;
    ovf_fed    = ovf_r;
    run_skip   = 1'b0;
    do_start   = 1'b0;
    if (!is_semi) begin
      case (seg_r)
        SEG_BASE: begin
          base_fed = ch;
          seg_fed  = SEG_STRAND;
        end
        SEG_STRAND: begin
          strand_fed = ch;
          seg_fed    = SEG_CODE_START;
        end
        SEG_CODE_START: begin
          if (ch_dig) begin
            num_fed  = 1'b1;
            code_fed = CODE_BITS'(ch_val);
            cnt_fed  = DIGIT_CNT_W'(1);
            seg_fed  = SEG_CODE_NUM;
          end else begin
            num_fed  = 1'b0;
            code_fed = CODE_BITS'(ch);
            cnt_fed  = '0;
            seg_fed  = SEG_CODE_LET;
          end
        end
        SEG_CODE_NUM: begin
          if (ch_dig) begin
            code_fed = code_acc;
            if (cnt_r != DIGIT_CNT_MAX) cnt_fed = cnt_r + 1'b1;
          end else begin
            seg_fed  = SEG_SKIP;
            run_skip = !ch_flag;
          end
        end
        SEG_CODE_LET: begin
          seg_fed  = SEG_SKIP;
          run_skip = !ch_flag;
        end
        SEG_SKIP: begin
          run_skip = 1'b1;
        end
        default: begin
          seg_fed = seg_r;
        end
      endcase

      if (run_skip) begin
        case (skip_r)
          SK_EXPECT: begin
            if (ch == CH_COMMA) skip_fed = SK_COMMA;
            else do_start = 1'b1;
          end
          SK_COMMA: begin
            do_start = 1'b1;
          end
          SK_MINUS: begin
            if (ch_dig) begin
              mag_fed  = SKIP_W'(ch_val);
              skip_fed = SK_DIGITS;
            end else begin
              skip_fed = SK_STOP;
            end
          end
          SK_DIGITS: begin
            if (ch_dig) begin
              mag_fed = mag_acc;
              ovf_fed = ovf_r | mag_sat;
            end else if (!num_ok(mag_r, neg_r, ovf_r)) begin
              skip_fed = SK_STOP;
            end else if (ch == CH_COMMA) begin
              skip_fed = SK_COMMA;
            end else begin
              do_start = 1'b1;
            end
          end
          default: begin
            skip_fed = skip_r;
          end
        endcase
      end

      if (do_start) begin
        ovf_fed = 1'b0;
        if (ch == CH_MINUS) begin
          neg_fed  = 1'b1;
          mag_fed  = '0;
          skip_fed = SK_MINUS;
        end else if (ch_dig) begin
          neg_fed  = 1'b0;
          mag_fed  = SKIP_W'(ch_val);
          skip_fed = SK_DIGITS;
        end else begin
          skip_fed = SK_STOP;
        end
      end
    end

    seg_nxt    = seg_r;
    skip_nxt   = skip_r;
    base_nxt   = base_r;
    strand_nxt = strand_r;
    code_nxt   = code_r;
    cnt_nxt    = cnt_r;
    num_nxt    = num_r;
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    ovf_nxt    = ovf_r;
    if (accept) begin
      if (fin) begin
        seg_nxt    = SEG_BASE;
        skip_nxt   = SK_EXPECT;
        base_nxt   = '0;
        strand_nxt = '0;
        code_nxt   = '0;
        cnt_nxt    = '0;
        num_nxt    = 1'b0;
        mag_nxt    = '0;
        neg_nxt    = 1'b0;
        ovf_nxt    = 1'b0;
      end else begin
        seg_nxt    = seg_fed;
        skip_nxt   = skip_fed;
        base_nxt   = base_fed;
        strand_nxt = strand_fed;
        code_nxt   = code_fed;
        cnt_nxt    = cnt_fed;
        num_nxt    = num_fed;
        mag_nxt    = mag_fed;
        neg_nxt    = neg_fed;
        ovf_nxt    = ovf_fed;
      end
    end
  end

  // outputs: which results this character gives
  always_comb begin
    feed_hdr  = !is_semi && (((seg_r == SEG_CODE_NUM) && !ch_dig) || (seg_r == SEG_CODE_LET));
    feed_skip = !is_semi && (seg_r == SEG_SKIP) && (skip_r == SK_DIGITS) && !ch_dig &&
                num_ok(mag_r, neg_r, ovf_r);
    end_hdr   = fin && ((seg_fed == SEG_CODE_NUM) || (seg_fed == SEG_CODE_LET));
    end_skip  = fin && (seg_fed == SEG_SKIP) && (skip_fed == SK_DIGITS) &&
                num_ok(mag_fed, neg_fed, ovf_fed);
    end_any   = end_hdr || (fin && (seg_fed == SEG_SKIP));

    push_data.hdr_v   = feed_hdr || end_hdr;
    push_data.skip_v  = feed_skip || end_skip;
    push_data.end_v   = end_any;
    push_data.base    = base_fed;
    push_data.strand  = strand_fed;
    push_data.numeric = num_fed;
    push_data.code    = CODE_ID_W'(code_fed);
    push_data.count   = cnt_fed;
    push_data.flag    = FLAG_NONE;
    if (feed_hdr && (ch == CH_QUEST)) push_data.flag = FLAG_QUEST;
    else if (feed_hdr && (ch == CH_DOT)) push_data.flag = FLAG_DOT;
    if (feed_skip) begin
      push_data.skip_val = neg_r ? (SKIP_W'(0) - mag_r) : mag_r;
    end else begin
      push_data.skip_val = neg_fed ? (SKIP_W'(0) - mag_fed) : mag_fed;
    end
    push = accept && (push_data.hdr_v || push_data.skip_v || push_data.end_v);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r    <= SEG_BASE;
      skip_r   <= SK_EXPECT;
      base_r   <= '0;
      strand_r <= '0;
      code_r   <= '0;
      cnt_r    <= '0;
      num_r    <= 1'b0;
      mag_r    <= '0;
      neg_r    <= 1'b0;
      ovf_r    <= 1'b0;
    end else begin
      seg_r    <= seg_nxt;
      skip_r   <= skip_nxt;
      base_r   <= base_nxt;
      strand_r <= strand_nxt;
      code_r   <= code_nxt;
      cnt_r    <= cnt_nxt;
      num_r    <= num_nxt;
      mag_r    <= mag_nxt;
      neg_r    <= neg_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  `MTSP_ASSERT_IMPL(a_hdr_from_code, clk, rst_n, push_data.hdr_v,
    (seg_r == SEG_CODE_START) || (seg_r == SEG_CODE_NUM) || (seg_r == SEG_CODE_LET),
    "header produced outside the mod code phases")
  `MTSP_ASSERT_IMPL(a_end_clears, clk, rst_n, accept && fin,
    ##1 ((seg_r == SEG_BASE) && (skip_r == SK_EXPECT)),
    "segment end did not return the parser to its start")

endmodule

### rtl/core/mtsp_queue.sv
// short bundle queue between the parser front end and the output back end
// depends on mtsp_pkg for the bundle type and depth
`include "assert_macros.svh"

module mtsp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mtsp_pkg::bundle_t   push_data,
  input  logic                pop,
  output mtsp_pkg::bundle_t   head,
  output mtsp_pkg::q_status_t q_st
);
  import mtsp_pkg::*;

  bundle_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign head       = mem_r[rd_ptr_r];
  assign q_st.full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_st.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `MTSP_ASSERT(a_no_overfill, clk, rst_n, !(push && q_st.full),
    "bundle written into a full queue")
  `MTSP_ASSERT(a_no_underrun, clk, rst_n, !(pop && q_st.empty),
    "bundle taken from an empty queue")

endmodule

### rtl/core/mtsp_back.sv
// back end: splits each queued bundle into result transactions, one per
// cycle unless stalled, via a registered output stage; uses mtsp_pkg
`include "assert_macros.svh"

module mtsp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mtsp_pkg::bundle_t   head,
  input  mtsp_pkg::q_status_t q_st,
  output logic                pop,
  mtsp_item_if.source         out_ch
);
  import mtsp_pkg::*;

  // bit 0 header, bit 1 skip, bit 2 end
  logic [2:0]             taken_r, taken_nxt;
  logic [2:0]             remain, pick;
  logic                   last, out_free, load;

  logic                   valid_r, valid_nxt;
  item_kind_t             kind_r;
  logic [7:0]             base_r, strand_r;
  logic                   numeric_r;
  logic [CODE_ID_W-1:0]   code_r;
  logic [DIGIT_CNT_W-1:0] count_r;
  code_flag_t             flag_r;
  logic [SKIP_W-1:0]      skip_r;
  logic                   run_end_r;

  always_comb begin
    remain = {head.end_v, head.skip_v, head.hdr_v} & ~taken_r;
    if (remain[0]) pick = 3'b001;
    else if (remain[1]) pick = 3'b010;
    else pick = 3'b100;
    last      = (remain & ~pick) == 3'b000;
    out_free  = !valid_r || out_ch.ready;
    load      = out_free && !q_st.empty;
    pop       = load && last;
    taken_nxt = taken_r;
    if (load) taken_nxt = last ? 3'b000 : (taken_r | pick);
    valid_nxt = load ? 1'b1 : (valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r <= 3'b000;
      valid_r <= 1'b0;
    end else begin
      taken_r <= taken_nxt;
      valid_r <= valid_nxt;
    end
  end

  // payload, header fields only on headers and skip only on skip items
  always_ff @(posedge clk) begin
    if (load) begin
      run_end_r <= last;
      if (pick[0]) begin
        kind_r    <= KIND_HEADER;
        base_r    <= head.base;
        strand_r  <= head.strand;
        numeric_r <= head.numeric;
        code_r    <= head.code;
        count_r   <= head.count;
        flag_r    <= head.flag;
        skip_r    <= '0;
      end else if (pick[1]) begin
        kind_r    <= KIND_SKIP;
        base_r    <= '0;
        strand_r  <= '0;
        numeric_r <= 1'b0;
        code_r    <= '0;
        count_r   <= '0;
        flag_r    <= FLAG_NONE;
        skip_r    <= head.skip_val;
      end else begin
        kind_r    <= KIND_END;
        base_r    <= '0;
        strand_r  <= '0;
        numeric_r <= 1'b0;
        code_r    <= '0;
        count_r   <= '0;
        flag_r    <= FLAG_NONE;
        skip_r    <= '0;
      end
    end
  end

  assign out_ch.valid            = valid_r;
  assign out_ch.item_kind        = kind_r;
  assign out_ch.base_char        = base_r;
  assign out_ch.strand_char      = strand_r;
  assign out_ch.code_is_numeric  = numeric_r;
  assign out_ch.code_id          = code_r;
  assign out_ch.code_digit_count = count_r;
  assign out_ch.code_flag        = flag_r;
  assign out_ch.skip_value       = skip_r;
  assign out_ch.run_end          = run_end_r;

  `MTSP_ASSERT_IMPL(a_head_has_work, clk, rst_n, !q_st.empty, remain != 3'b000,
    "queued bundle with no result left to send")

endmodule

### test/mm_tag_stream_parser_top_test.sv
// self-checking testbench for mm_tag_stream_parser_top: a short script of tag
// characters, then random tag strings, checked against a behavioural parser
// depends on mtsp_pkg, mtsp_channels and the parser rtl
module mm_tag_stream_parser_top_test;
  import mtsp_pkg::*;

  localparam int PERIOD = 12;
  localparam int RANDOM_CHARS = 400;
  // default CODE_BITS of 24 saturates at all ones in the 24-bit field
  localparam logic [CODE_ID_W-1:0] CODE_CAP = '1;

  typedef struct {
    item_kind_t             kind;
    logic [7:0]             base;
    logic [7:0]             strand;
    logic                   numeric;
    logic [CODE_ID_W-1:0]   code;
    logic [DIGIT_CNT_W-1:0] count;
    code_flag_t             flag;
    logic [SKIP_W-1:0]      skip;
    logic                   last;
  } tag_item_t;

  typedef struct {
    logic [7:0] ch;
    logic       fin;
    bit         fixed;
    int         n_fixed;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mtsp_char_if char_ch ();
  mtsp_item_if item_ch ();

  mm_tag_stream_parser_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (char_ch),
    .out_ch (item_ch)
  );

  always #(PERIOD / 2) clk = ~clk;

  // rows with fixed set take their results from fixed_items, in order
  script_row_t script [25] = '{
    '{CH_SEMI, 1'b0, 1'b1, 0},  // empty segment straight out of reset
    '{"a",     1'b0, 1'b1, 0},
    '{"b",     1'b0, 1'b1, 0},
    '{CH_SEMI, 1'b0, 1'b1, 0},  // two characters only, dropped
    '{"C",     1'b0, 1'b1, 0},
    '{"+",     1'b0, 1'b1, 0},
    '{"m",     1'b0, 1'b1, 0},
    '{"?",     1'b0, 1'b1, 1},
    '{",",     1'b0, 1'b0, 0},
    '{"3",     1'b0, 1'b0, 0},
    '{",",     1'b0, 1'b0, 0},
    '{"-",     1'b0, 1'b0, 0},
    '{"2",     1'b0, 1'b0, 0},
    '{"+",     1'b0, 1'b0, 0},  // plus sign stops the skip list
    '{"5",     1'b0, 1'b0, 0},
    '{CH_SEMI, 1'b0, 1'b0, 0},
    '{8'hFF,   1'b0, 1'b0, 0},
    '{8'h00,   1'b0, 1'b0, 0},
    '{"0",     1'b0, 1'b0, 0},  // leading zero on a numeric code
    '{"7",     1'b0, 1'b0, 0},
    '{".",     1'b0, 1'b1, 1},
    '{"1",     1'b1, 1'b0, 0},  // final mark closes the open number
    '{"A",     1'b0, 1'b0, 0},
    '{"-",     1'b0, 1'b0, 0},
    '{"a",     1'b1, 1'b1, 2}   // letter code ends the string
  };

  tag_item_t fixed_items [4] = '{
    '{KIND_HEADER, "C", "+", 1'b0, 24'h00006D, 4'd0, FLAG_QUEST, 32'd0, 1'b1},
    '{KIND_HEADER, 8'hFF, 8'h00, 1'b1, 24'd7, 4'd2, FLAG_DOT, 32'd0, 1'b1},
    '{KIND_HEADER, "A", "-", 1'b0, 24'h000061, 4'd0, FLAG_NONE, 32'd0, 1'b0},
    '{KIND_END, 8'h00, 8'h00, 1'b0, 24'd0, 4'd0, FLAG_NONE, 32'd0, 1'b1}
  };

  tag_item_t  due_items [$];
  tag_item_t  burst [$];
  logic [7:0] tag_text [$];

  int fault_count = 0;
  int hdr_seen = 0;
  int skip_seen = 0;
  int end_seen = 0;
  int strings_sent = 0;
  int chars_sent = 0;
  bit quiet_spell = 1'b0;

  // parser state mirrored in the testbench
  seg_phase_t             seg_ph;
  skip_phase_t            sk_ph;
  logic [7:0]             base_acc;
  logic [7:0]             strand_acc;
  logic [CODE_ID_W-1:0]   code_acc;
  logic [DIGIT_CNT_W-1:0] digit_acc;
  logic                   numeric_acc;
  logic [SKIP_W-1:0]      mag;
  logic                   neg;
  logic                   ovf;

  function automatic logic is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic [3:0] digit_of(logic [7:0] c);
    return 4'(c - CH_ZERO);
  endfunction

  function automatic void add_result(item_kind_t k, code_flag_t f, logic [SKIP_W-1:0] v);
    tag_item_t r;
    r.kind = k;
    r.base = '0;
    r.strand = '0;
    r.numeric = 1'b0;
    r.code = '0;
    r.count = '0;
    r.flag = FLAG_NONE;
    r.skip = '0;
    r.last = 1'b0;
    if (k == KIND_HEADER) begin
      r.base = base_acc;
      r.strand = strand_acc;
      r.numeric = numeric_acc;
      r.code = code_acc;
      r.count = digit_acc;
      r.flag = f;
    end else if (k == KIND_SKIP) begin
      r.skip = v;
    end
    burst.insert(burst.size(), r);
  endfunction

  function automatic void clear_parse();
    seg_ph = SEG_BASE;
    sk_ph = SK_EXPECT;
    base_acc = '0;
    strand_acc = '0;
    code_acc = '0;
    digit_acc = '0;
    numeric_acc = 1'b0;
    mag = '0;
    neg = 1'b0;
    ovf = 1'b0;
  endfunction

  function automatic void begin_number(logic [7:0] c);
    ovf = 1'b0;
    if (c == CH_MINUS) begin
      neg = 1'b1;
      mag = '0;
      sk_ph = SK_MINUS;
    end else if (is_digit(c)) begin
      neg = 1'b0;
      mag = SKIP_W'(digit_of(c));
      sk_ph = SK_DIGITS;
    end else begin
      sk_ph = SK_STOP;
    end
  endfunction

  function automatic logic close_number();
    if (ovf || (!neg && mag > NUM_POS_MAX)) return 1'b0;
    add_result(KIND_SKIP, FLAG_NONE, neg ? (32'd0 - mag) : mag);
    return 1'b1;
  endfunction

  function automatic void skip_step(logic [7:0] c);
    logic [63:0] t;
    case (sk_ph)
      SK_EXPECT: begin
        if (c == CH_COMMA) sk_ph = SK_COMMA;
        else begin_number(c);
      end
      SK_COMMA: begin_number(c);
      SK_MINUS: begin
        if (is_digit(c)) begin
          mag = SKIP_W'(digit_of(c));
          sk_ph = SK_DIGITS;
        end else begin
          sk_ph = SK_STOP;
        end
      end
      SK_DIGITS: begin
        if (is_digit(c)) begin
          t = 64'(mag) * 10 + 64'(digit_of(c));
          // magnitude pins at 2^31 once it runs past
          if (t > 64'(NUM_CAP)) begin
            t = 64'(NUM_CAP);
            ovf = 1'b1;
          end
          mag = t[SKIP_W-1:0];
        end else if (!close_number()) begin
          sk_ph = SK_STOP;
        end else if (c == CH_COMMA) begin
          sk_ph = SK_COMMA;
        end else begin
          begin_number(c);
        end
      end
      default: ;
    endcase
  endfunction

  // the character after the mod code releases the header
  function automatic void code_done(logic [7:0] c);
    seg_ph = SEG_SKIP;
    if (c == CH_QUEST) begin
      add_result(KIND_HEADER, FLAG_QUEST, '0);
    end else if (c == CH_DOT) begin
      add_result(KIND_HEADER, FLAG_DOT, '0);
    end else begin
      add_result(KIND_HEADER, FLAG_NONE, '0);
      skip_step(c);
    end
  endfunction

  function automatic void end_segment();
    if (seg_ph == SEG_CODE_NUM || seg_ph == SEG_CODE_LET) begin
      add_result(KIND_HEADER, FLAG_NONE, '0);
      add_result(KIND_END, FLAG_NONE, '0);
    end else if (seg_ph == SEG_SKIP) begin
      if (sk_ph == SK_DIGITS) void'(close_number());
      add_result(KIND_END, FLAG_NONE, '0);
    end
    clear_parse();
  endfunction

  // works out the results of one character; queues them unless the caller
  // supplies its own
  function automatic void parse_tag_char(logic [7:0] c, logic fin, bit keep);
    logic [63:0] t;
    burst.delete();
    if (c == CH_SEMI) begin
      end_segment();
    end else begin
      case (seg_ph)
        SEG_BASE: begin
          base_acc = c;
          seg_ph = SEG_STRAND;
        end
        SEG_STRAND: begin
          strand_acc = c;
          seg_ph = SEG_CODE_START;
        end
        SEG_CODE_START: begin
          if (is_digit(c)) begin
            numeric_acc = 1'b1;
            code_acc = CODE_ID_W'(digit_of(c));
            digit_acc = 4'd1;
            seg_ph = SEG_CODE_NUM;
          end else begin
            numeric_acc = 1'b0;
            code_acc = CODE_ID_W'(c);
            digit_acc = '0;
            seg_ph = SEG_CODE_LET;
          end
        end
        SEG_CODE_NUM: begin
          if (is_digit(c)) begin
            t = 64'(code_acc) * 10 + 64'(digit_of(c));
            code_acc = (t > 64'(CODE_CAP)) ? CODE_CAP : t[CODE_ID_W-1:0];
            if (digit_acc != DIGIT_CNT_MAX) digit_acc = digit_acc + 1'b1;
          end else begin
            code_done(c);
          end
        end
        SEG_CODE_LET: code_done(c);
        default: skip_step(c);
      endcase
      if (fin) end_segment();
    end
    if (burst.size() != 0) burst[burst.size() - 1].last = 1'b1;
    if (keep) foreach (burst[i]) due_items.insert(due_items.size(), burst[i]);
  endfunction

  function automatic int draw_wait();
    return (quiet_spell || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) tag_text.insert(tag_text.size(), s[i]);
  endfunction

  function automatic void put_digits(int n);
    repeat (n) tag_text.insert(tag_text.size(), CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  // mostly well-formed tag strings with random content, some damage and noise
  function automatic void draw_tag_text();
    string bases = "ACGTUN";
    string codes = "mhfcagoe";
    int nseg;
    int nskip;
    logic [63:0] v;
    tag_text.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) tag_text.insert(tag_text.size(), 8'($urandom));
      return;
    end
    nseg = $urandom_range(1, 4);
    for (int s = 0; s < nseg; s++) begin
      if (s > 0) put_text(";");
      if ($urandom_range(0, 11) == 0) begin
        repeat ($urandom_range(0, 2))
          tag_text.insert(tag_text.size(), bases[$urandom_range(0, 5)]);
        continue;
      end
      if ($urandom_range(0, 9) == 0) tag_text.insert(tag_text.size(), 8'($urandom));
      else tag_text.insert(tag_text.size(), bases[$urandom_range(0, 5)]);
      if ($urandom_range(0, 9) == 0) tag_text.insert(tag_text.size(), 8'($urandom));
      else put_text($urandom_range(0, 1) ? "+" : "-");
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: tag_text.insert(tag_text.size(), codes[$urandom_range(0, 7)]);
        5, 6, 7: begin
          if ($urandom_range(0, 3) == 0) put_text("00");
          put_text($sformatf("%0d", $urandom_range(0, 99999)));
        end
        8: put_digits($urandom_range(7, 18));
        default: tag_text.insert(tag_text.size(), 8'($urandom));
      endcase
      case ($urandom_range(0, 3))
        2: put_text("?");
        3: put_text(".");
        default: ;
      endcase
      nskip = $urandom_range(0, 5);
      for (int k = 0; k < nskip; k++) begin
        if ($urandom_range(0, 7) != 0) put_text(",");
        if ($urandom_range(0, 2) == 0) put_text("-");
        if ($urandom_range(0, 7) == 0) put_text("0");
        if ($urandom_range(0, 5) == 0) begin
          put_digits($urandom_range(10, 13));
        end else begin
          case ($urandom_range(0, 4))
            0: v = $urandom_range(0, 20);
            1: v = $urandom_range(0, 99999);
            2: v = $urandom;
            3: v = $urandom >> $urandom_range(0, 31);
            default: begin
              case ($urandom_range(0, 3))
                0: v = 64'd2147483647;
                1: v = 64'd2147483648;
                2: v = 64'd2147483649;
                default: v = 64'd4294967295;
              endcase
            end
          endcase
          put_text($sformatf("%0d", v));
        end
        case ($urandom_range(0, 15))
          0: put_text("+");
          1: put_text(",");
          2: tag_text.insert(tag_text.size(), 8'($urandom));
          default: ;
        endcase
      end
    end
    if ($urandom_range(0, 2) == 0) put_text(";");
  endfunction

  function automatic string show_item(tag_item_t r);
    return $sformatf("kind %0d base %h strand %h num %b code %h cnt %0d flag %0d skip %0d end %b",
                     r.kind, r.base, r.strand, r.numeric, r.code, r.count, r.flag,
                     $signed(r.skip), r.last);
  endfunction

  function automatic void note_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("mismatch: %s", msg);
  endfunction

  task automatic offer_char(input logic [7:0] c, input logic fin);
    int gap;
    gap = draw_wait();
    @(negedge clk);
    if (gap > 0) begin
      char_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    char_ch.valid <= 1'b1;
    char_ch.text_char <= c;
    char_ch.final_char <= fin;
    @(posedge clk);
    while (!char_ch.ready) @(posedge clk);
    chars_sent++;
  endtask

  // hold the input off until every outstanding result has been taken
  task automatic settle();
    @(negedge clk);
    char_ch.valid <= 1'b0;
    while (due_items.size() != 0) @(posedge clk);
  endtask

  initial begin
    int stall;
    item_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_wait();
      @(negedge clk);
      if (stall > 0) begin
        item_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      item_ch.ready <= 1'b1;
      @(posedge clk);
      while (!item_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    tag_item_t want;
    tag_item_t got;
    if (rst_n && item_ch.valid && item_ch.ready) begin
      got.kind = item_kind_t'(item_ch.item_kind);
      got.base = item_ch.base_char;
      got.strand = item_ch.strand_char;
      got.numeric = item_ch.code_is_numeric;
      got.code = item_ch.code_id;
      got.count = item_ch.code_digit_count;
      got.flag = code_flag_t'(item_ch.code_flag);
      got.skip = item_ch.skip_value;
      got.last = item_ch.run_end;
      if (due_items.size() == 0) begin
        note_fault({"unexpected transaction: ", show_item(got)});
      end else begin
        want = due_items.pop_front();
        if (got.kind !== want.kind || got.base !== want.base ||
            got.strand !== want.strand || got.numeric !== want.numeric ||
            got.code !== want.code || got.count !== want.count ||
            got.flag !== want.flag || got.skip !== want.skip ||
            got.last !== want.last) begin
          note_fault({"expected ", show_item(want), " got ", show_item(got)});
        end
        case (want.kind)
          KIND_HEADER: hdr_seen++;
          KIND_SKIP:   skip_seen++;
          default:     end_seen++;
        endcase
      end
    end
  end

  initial begin
    int fx;
    int random_chars;
    char_ch.valid = 1'b0;
    char_ch.text_char = '0;
    char_ch.final_char = 1'b0;
    clear_parse();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    fx = 0;
    for (int i = 0; i < $size(script); i++) begin
      offer_char(script[i].ch, script[i].fin);
      parse_tag_char(script[i].ch, script[i].fin, !script[i].fixed);
      for (int j = 0; j < script[i].n_fixed; j++) begin
        due_items.insert(due_items.size(), fixed_items[fx]);
        fx++;
      end
    end
    settle();

    random_chars = 0;
    while (random_chars < RANDOM_CHARS) begin
      // spells with no idling on either side
      if ($urandom_range(0, 5) == 0) quiet_spell = !quiet_spell;
      draw_tag_text();
      foreach (tag_text[i]) begin
        offer_char(tag_text[i], i == tag_text.size() - 1);
        parse_tag_char(tag_text[i], i == tag_text.size() - 1, 1'b1);
      end
      random_chars += tag_text.size();
      strings_sent++;
      if ($urandom_range(0, 14) == 0) settle();
    end
    settle();
    repeat (24) @(posedge clk);

    $display("sent %0d characters: the directed script and %0d random tag strings",
             chars_sent, strings_sent);
    $display("checked %0d headers, %0d skip values and %0d segment ends",
             hdr_seen, skip_seen, end_seen);
    if (fault_count == 0) begin
      $display("mm_tag_stream_parser_top_test: done, clean");
    end else begin
      $display("mm_tag_stream_parser_top_test: done, errors");
    end
    $finish;
  end

  initial begin
    #(PERIOD * 300_000);
    $display("timeout with %0d results outstanding", due_items.size());
    $display("mm_tag_stream_parser_top_test: done, errors");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/mtsp_pkg.sv
rtl/core/mtsp_channels.sv
rtl/core/mtsp_front.sv
rtl/core/mtsp_queue.sv
rtl/core/mtsp_back.sv
rtl/core/mm_tag_stream_parser_top.sv
test/mm_tag_stream_parser_top_test.sv
